@@ rtl/wsts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wsts_pkg: shared types and constants for the weighted sum-tree sampler
// Node layout: leaves at 0..LEAVES-1, each higher level follows, root last.
// ----------------------------------------------------------------------------
package wsts_pkg;
	localparam int LEAVES     = 1024;
	localparam int LEAF_WIDTH = 24;
	localparam int LEVELS     = $clog2(LEAVES);
	localparam int NODES      = 2 * LEAVES - 1;
	localparam int NODE_W     = $clog2(NODES);
	localparam int LEAF_IDX_W = LEVELS;
	localparam int SUM_W      = 34;
	localparam int IDX_W      = 10;
	localparam int RATE_W     = 24;
	localparam int LVL_W      = $clog2(LEVELS + 1);

	typedef enum logic [1:0] {
		KIND_SET    = 2'd0,
		KIND_SELECT = 2'd1,
		KIND_READ   = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic [LEAF_IDX_W-1:0]  leaf;
		logic [SUM_W-1:0]       amount;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_RD,
		ST_WAIT,
		ST_STEP,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

@@ rtl/wsts_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wsts_front: input decode and command queue
// Saturates set rates, wraps indexes, and buffers commands in a 2-entry FIFO.
// ----------------------------------------------------------------------------
module wsts_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire  [47:0]          s_tdata,
	output logic                 q_valid,
	input  wire                  q_pop,
	output wsts_pkg::cmd_t       q_cmd
);
	localparam logic [wsts_pkg::SUM_W-1:0] LEAF_MAX =
		wsts_pkg::SUM_W'((64'd1 << wsts_pkg::LEAF_WIDTH) - 64'd1);

	wsts_pkg::cmd_t        fifo_q [2];
	logic                  wr_ptr_q, rd_ptr_q;
	logic [1:0]            cnt_q;
	wsts_pkg::cmd_t        cmd_in;
	logic [9:0]            idx_in;
	logic [wsts_pkg::SUM_W-1:0] amt_in;
	logic                  push;

	assign idx_in = s_tdata[11:2];
	assign amt_in = s_tdata[45:12];

	always_comb begin
		cmd_in.kind   = wsts_pkg::kind_t'(s_tdata[1:0]);
		cmd_in.leaf   = idx_in[wsts_pkg::LEAF_IDX_W-1:0];
		cmd_in.amount = amt_in;
		if (cmd_in.kind == wsts_pkg::KIND_SET && amt_in > LEAF_MAX) begin
			cmd_in.amount = LEAF_MAX;
		end
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule
`default_nettype wire

@@ rtl/wsts_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wsts_back: tree engine
// One tree level per step through a node memory with one read and one write port; result register.
// ----------------------------------------------------------------------------
module wsts_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  q_valid,
	output logic                 q_pop,
	input  wsts_pkg::cmd_t       q_cmd,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output logic [71:0]          m_tdata
);
	localparam int NW = wsts_pkg::NODE_W;
	localparam int LW = wsts_pkg::LEAF_IDX_W;
	localparam int SW = wsts_pkg::SUM_W;

	logic [SW-1:0]   mem [wsts_pkg::NODES];
	logic [SW-1:0]   rdata_q;
	logic [SW-1:0]   total_q;
	logic            init_q;

	wsts_pkg::state_t state_q, state_d;
	wsts_pkg::cmd_t   cmd_q;
	logic [NW-1:0]    clr_q;
	logic [LW-1:0]    pos_q;     // current position within level
	logic [NW-1:0]    lstart_q;  // first node of current level
	logic [NW:0]      llen_q;    // nodes in current level
	logic [SW-1:0]    delta_q;   // value - old, modulo
	logic [SW-1:0]    draw_q;
	logic [SW-1:0]    leafv_q;
	logic             out_busy;

	logic            we, re;
	logic [NW-1:0]   waddr, raddr;
	logic [SW-1:0]   wdata;

	// next level: start += len, len /= 2
	logic [NW-1:0]   next_start;
	logic [NW:0]     next_len;
	assign next_start = lstart_q + llen_q[NW-1:0];
	assign next_len   = llen_q >> 1;

	assign out_busy = m_tvalid && !m_tready;

	// address of the left child one level down in a select walk
	logic            go_right;
	logic [LW-1:0]   sel_pos;
	assign go_right = (rdata_q <= draw_q);
	assign sel_pos  = pos_q | LW'(go_right);
	function automatic logic [NW-1:0] state_sel_addr();
		logic [NW-1:0] start_dn;
		start_dn = lstart_q - NW'(llen_q << 1);
		return start_dn + NW'({sel_pos, 1'b0});
	endfunction

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		we      = 1'b0;
		re      = 1'b0;
		waddr   = clr_q;
		raddr   = lstart_q + NW'(pos_q);
		wdata   = '0;
		case (state_q)
			wsts_pkg::ST_CLEAR: begin
				we = 1'b1;
				if (clr_q == NW'(wsts_pkg::NODES - 1)) state_d = wsts_pkg::ST_IDLE;
			end
			wsts_pkg::ST_IDLE: begin
				if (q_valid && !m_tvalid && !init_q) begin
					q_pop = 1'b1;
					case (q_cmd.kind)
						wsts_pkg::KIND_CLEAR:  state_d = wsts_pkg::ST_CLEAR;
						wsts_pkg::KIND_SELECT: begin
							re = 1'b1;
							raddr = NW'(wsts_pkg::NODES - 3);
							state_d = (wsts_pkg::LEVELS == 0) ? wsts_pkg::ST_DONE
								: wsts_pkg::ST_WAIT;
						end
						default: begin
							re = 1'b1;
							raddr = NW'(q_cmd.leaf);
							state_d = wsts_pkg::ST_WAIT;
						end
					endcase
				end
			end
			wsts_pkg::ST_WAIT: begin
				state_d = (cmd_q.kind == wsts_pkg::KIND_READ) ? wsts_pkg::ST_DONE
					: wsts_pkg::ST_STEP;
			end
			wsts_pkg::ST_STEP: begin
				if (cmd_q.kind == wsts_pkg::KIND_SET) begin
					// rdata_q holds node at lstart_q + pos_q
					we    = 1'b1;
					waddr = lstart_q + NW'(pos_q);
					wdata = (llen_q == (NW+1)'(wsts_pkg::LEAVES)) ? cmd_q.amount
						: rdata_q + delta_q;
					if (llen_q == (NW+1)'(1)) begin
						state_d = wsts_pkg::ST_DONE;
					end else begin
						re = 1'b1;
						raddr = next_start + NW'(pos_q >> 1);
						state_d = wsts_pkg::ST_WAIT;
					end
				end else begin
					// select: rdata_q = left child at this level
					if (llen_q == (NW+1)'(wsts_pkg::LEAVES)) begin
						state_d = wsts_pkg::ST_DONE;
					end else begin
						re = 1'b1;
						raddr = state_sel_addr();
						state_d = wsts_pkg::ST_WAIT;
					end
				end
			end
			wsts_pkg::ST_DONE: begin
				if (!out_busy) state_d = wsts_pkg::ST_IDLE;
			end
			default: state_d = wsts_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			wsts_pkg::ST_IDLE: begin
				cmd_q <= q_cmd;
				if (q_cmd.kind == wsts_pkg::KIND_SELECT) begin
					lstart_q <= NW'(wsts_pkg::NODES - 3);
					llen_q   <= (NW+1)'(2);
					pos_q    <= '0;
					draw_q   <= q_cmd.amount;
				end else begin
					lstart_q <= '0;
					llen_q   <= (NW+1)'(wsts_pkg::LEAVES);
					pos_q    <= q_cmd.leaf;
				end
			end
			wsts_pkg::ST_WAIT: begin
				if (cmd_q.kind == wsts_pkg::KIND_SET
					&& llen_q == (NW+1)'(wsts_pkg::LEAVES)) begin
					delta_q <= cmd_q.amount - rdata_q;
				end
				if (cmd_q.kind == wsts_pkg::KIND_READ) leafv_q <= rdata_q;
			end
			wsts_pkg::ST_STEP: begin
				if (cmd_q.kind == wsts_pkg::KIND_SET) begin
					lstart_q <= next_start;
					llen_q   <= next_len;
					pos_q    <= pos_q >> 1;
					if (llen_q == (NW+1)'(wsts_pkg::LEAVES)) leafv_q <= cmd_q.amount;
				end else begin
					if (go_right) draw_q <= draw_q - rdata_q;
					pos_q    <= (llen_q == (NW+1)'(wsts_pkg::LEAVES)) ? sel_pos
						: LW'({sel_pos, 1'b0});
					lstart_q <= lstart_q - NW'(llen_q << 1);
					llen_q   <= llen_q << 1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= wsts_pkg::ST_CLEAR;
			clr_q    <= '0;
			init_q   <= 1'b1;
			m_tvalid <= 1'b0;
			total_q  <= '0;
			m_tdata  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == wsts_pkg::ST_CLEAR) begin
				if (state_d == wsts_pkg::ST_IDLE) begin
					clr_q  <= '0;
					init_q <= 1'b0;
					if (!init_q) begin
						total_q  <= '0;
						m_tvalid <= 1'b1;
						m_tdata  <= '0;
					end
				end else begin
					clr_q <= clr_q + NW'(1);
				end
			end
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			if (state_q == wsts_pkg::ST_DONE && !out_busy) begin
				logic [SW-1:0]                tot;
				logic [wsts_pkg::IDX_W-1:0]   sel;
				logic [wsts_pkg::RATE_W-1:0]  rate;
				tot  = total_q;
				sel  = '0;
				rate = '0;
				if (cmd_q.kind == wsts_pkg::KIND_SET) tot = total_q + delta_q;
				if (cmd_q.kind == wsts_pkg::KIND_SELECT) begin
					sel = wsts_pkg::IDX_W'(pos_q);
				end else begin
					rate = wsts_pkg::RATE_W'(leafv_q);
				end
				total_q  <= tot;
				m_tvalid <= 1'b1;
				m_tdata  <= {4'd0, tot, rate, sel};
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/weighted_sum_tree_sampler.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_sum_tree_sampler: sum tree with weighted index selection
// Channel | dir | contents
// s_*     | in  | tdata: kind[1:0], leaf_index[11:2], amount[45:12]
// m_*     | out | tdata: selected_index[9:0], leaf_rate[33:10], total_rate[67:34]
// Set and select walk the tree one level per step, one node memory read per level;
// read takes a single leaf access; clear writes every node of the memory.
// The next dequeue waits until the result transaction has been accepted.
// After reset a clearing pass over every node runs before queued items run.
// A 2-entry command queue keeps input open for up to two commands while the engine or output stalls.
// ----------------------------------------------------------------------------
module weighted_sum_tree_sampler (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [47:0] s_tdata,   // kind, leaf_index, amount
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [71:0] m_tdata    // selected_index, leaf_rate, total_rate
);
	logic           q_valid, q_pop;
	wsts_pkg::cmd_t q_cmd;

	wsts_front u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata,
		.q_valid, .q_pop, .q_cmd
	);

	wsts_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_cmd,
		.m_tvalid, .m_tready, .m_tdata
	);
endmodule
`default_nettype wire

@@ rtl/wsts_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// wsts_checker: port-level checks
// Watches the stream ports of the sampler.
// ----------------------------------------------------------------------------
module wsts_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire [47:0] s_tdata,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [71:0] m_tdata
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed under stall");
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[71:68] == 4'd0)
		else $error("pad bits set");
	a_sel_norate: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[9:0] != 10'd0 |-> m_tdata[33:10] == 24'd0)
		else $error("select and rate both set");
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !$isunknown(m_tdata))
		else $error("unknown bits in output transaction");
endmodule

bind weighted_sum_tree_sampler wsts_checker u_wsts_checker (
	.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
);
`default_nettype wire
